### src/fpk_pkg.sv
`default_nettype none

package fpk_pkg;

    // operation codes carried in the input tuser field
    typedef enum logic [1:0] {
        ACT_DOWNPASS = 2'd0,
        ACT_UPPASS   = 2'd1,
        ACT_TIP      = 2'd2,
        ACT_INSCOST  = 2'd3
    } t_action;

    // fixed field widths of the stream payload
    localparam int ACTION_BITS = 2;
    localparam int LIMIT_BITS  = 16;
    localparam int OUT_CNT_BITS = 16;

    // applicable mask after reset: every state but inapplicable
    localparam logic [31:0] MASK_RESET = 32'd2046;

    // status produced by the set logic for one character
    typedef struct packed {
        logic changed;
        logic count_step;
        logic is_cost;
    } t_set_flags;

endpackage

`default_nettype wire

### src/fpk_set_logic.sv
`default_nettype none

module fpk_set_logic #(
    parameter int STATE_BITS = 11
) (
    input  fpk_pkg::t_action       i_action,
    input  logic [STATE_BITS-1:0]  i_left,
    input  logic [STATE_BITS-1:0]  i_right,
    input  logic [STATE_BITS-1:0]  i_node,
    input  logic [STATE_BITS-1:0]  i_parent,
    input  logic [STATE_BITS-1:0]  i_old,
    input  logic [STATE_BITS-1:0]  i_mask,
    output logic [STATE_BITS-1:0]  o_new_set,
    output fpk_pkg::t_set_flags    o_flags
);

    localparam logic [STATE_BITS-1:0] INAPPLIC_ONLY = STATE_BITS'(1);

    logic [STATE_BITS-1:0] lr_and;
    logic [STATE_BITS-1:0] lr_or;
    logic [STATE_BITS-1:0] np_and;
    logic                  l_app;
    logic                  r_app;
    logic                  n_app;
    logic                  p_app;

    // shared terms
    assign lr_and = i_left & i_right;
    assign lr_or  = i_left | i_right;
    assign np_and = i_node & i_parent;
    assign l_app  = |(i_left & i_mask);
    assign r_app  = |(i_right & i_mask);
    assign n_app  = |(i_node & i_mask);
    assign p_app  = |(i_parent & i_mask);

    // per-action set rules
    always_comb begin
        o_new_set          = '0;
        o_flags.changed    = 1'b0;
        o_flags.count_step = 1'b0;
        o_flags.is_cost    = 1'b0;
        unique case (i_action)
            fpk_pkg::ACT_DOWNPASS: begin
                if (|lr_and) begin
                    o_new_set = lr_and;
                end else if (l_app && r_app) begin
                    o_new_set          = lr_or & i_mask;
                    o_flags.count_step = 1'b1;
                end else begin
                    o_new_set = lr_or;
                end
                o_flags.changed = (o_new_set != i_old);
            end
            fpk_pkg::ACT_UPPASS: begin
                if (np_and == i_parent) begin
                    o_new_set = np_and;
                end else if (|lr_and) begin
                    o_new_set = i_node | (i_parent & lr_or);
                end else if (p_app && n_app) begin
                    o_new_set = (i_node | i_parent) & i_mask;
                end else begin
                    o_new_set = i_node | i_parent;
                end
                o_flags.changed = (o_new_set != i_old);
            end
            fpk_pkg::ACT_TIP: begin
                if ((i_node != INAPPLIC_ONLY) && (|np_and)) begin
                    o_new_set = np_and;
                end else begin
                    o_new_set = i_old;
                end
                o_flags.changed = (o_new_set != i_old);
            end
            fpk_pkg::ACT_INSCOST: begin
                // disjoint clipped subtree costs one insertion
                o_flags.count_step = ~|(i_node & lr_or);
                o_flags.is_cost    = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/fitch_parsimony_character_kernel.sv
`default_nettype none

// Fitch parsimony character kernel: one character per stream transaction, selected by
// tuser (downpass / root, uppass final, tip resolve, insertion cost). The block takes
// one transaction every cycle unless the result stream stalls; each result passes through
// the input register, then the set logic and run counter feed the result register.
// s_axis_tready drops only while both registers hold data and m_axis_tready is low.
// The step or cost count saturates at its all-ones value and, with the all-same flag,
// restarts after each transaction carrying tlast. The applicable mask is loaded through
// the cfg channel, which is always ready; write it only while the block is empty.
module fitch_parsimony_character_kernel #(
    parameter int STATE_BITS = 11,
    parameter int COUNT_BITS = 16,
    localparam int IN_RAW = 5 * STATE_BITS + fpk_pkg::LIMIT_BITS,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = STATE_BITS + fpk_pkg::OUT_CNT_BITS + 3,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: applicable mask
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [STATE_BITS-1:0]              i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // left_set, right_set, node_set, parent_set, old_set, cost_limit, zero pad
    input  logic [IN_W-1:0]                    s_axis_tdata,
    // action
    input  logic [fpk_pkg::ACTION_BITS-1:0]    s_axis_tuser,
    input  logic                               s_axis_tlast,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // new_set, changed, running_count, over_limit, all_same, zero pad
    output logic [OUT_W-1:0]                   m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int SB  = STATE_BITS;
    localparam int LB  = fpk_pkg::LIMIT_BITS;
    localparam int OCB = fpk_pkg::OUT_CNT_BITS;
    localparam int CMP_W = (COUNT_BITS > LB) ? COUNT_BITS : LB;
    localparam int WIDE_W = (CMP_W > OCB) ? CMP_W : OCB;

    // configuration register
    logic [SB-1:0] r_mask;

    // input register
    logic                 r_in_valid;
    fpk_pkg::t_action     r_in_action;
    logic [SB-1:0]        r_in_left;
    logic [SB-1:0]        r_in_right;
    logic [SB-1:0]        r_in_node;
    logic [SB-1:0]        r_in_parent;
    logic [SB-1:0]        r_in_old;
    logic [LB-1:0]        r_in_limit;
    logic                 r_in_last;

    // run state
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  r_unch;
    logic                  n_unch;

    // result register
    logic                 r_out_valid;
    logic [SB-1:0]        r_out_set;
    logic                 r_out_changed;
    logic [OCB-1:0]       r_out_count;
    logic                 r_out_over;
    logic                 r_out_same;
    logic                 r_out_last;

    logic                 in_fire;
    logic                 advance;
    logic [SB-1:0]        new_set;
    fpk_pkg::t_set_flags  flags;
    logic [WIDE_W-1:0]    cnt_wide;
    logic                 over;

    // handshake: the stage advances whenever the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // mask write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= SB'(fpk_pkg::MASK_RESET);
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_action <= fpk_pkg::t_action'(s_axis_tuser);
            r_in_left   <= s_axis_tdata[0*SB +: SB];
            r_in_right  <= s_axis_tdata[1*SB +: SB];
            r_in_node   <= s_axis_tdata[2*SB +: SB];
            r_in_parent <= s_axis_tdata[3*SB +: SB];
            r_in_old    <= s_axis_tdata[4*SB +: SB];
            r_in_limit  <= s_axis_tdata[5*SB +: LB];
            r_in_last   <= s_axis_tlast;
        end
    end

    // set rules
    fpk_set_logic #(
        .STATE_BITS (SB)
    ) u_set_logic (
        .i_action  (r_in_action),
        .i_left    (r_in_left),
        .i_right   (r_in_right),
        .i_node    (r_in_node),
        .i_parent  (r_in_parent),
        .i_old     (r_in_old),
        .i_mask    (r_mask),
        .o_new_set (new_set),
        .o_flags   (flags)
    );

    // saturating count and all-same tracking
    always_comb begin
        n_cnt = r_cnt;
        if (flags.count_step && (r_cnt != {COUNT_BITS{1'b1}})) begin
            n_cnt = r_cnt + COUNT_BITS'(1);
        end
        n_unch = r_unch && !flags.changed;
    end

    assign cnt_wide = WIDE_W'(n_cnt);
    assign over     = flags.is_cost && (CMP_W'(n_cnt) > CMP_W'(r_in_limit));

    // run state update, restarted after the closing character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_unch <= 1'b1;
        end else if (advance) begin
            if (r_in_last) begin
                r_cnt  <= '0;
                r_unch <= 1'b1;
            end else begin
                r_cnt  <= n_cnt;
                r_unch <= n_unch;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_set     <= new_set;
            r_out_changed <= flags.changed;
            r_out_count   <= cnt_wide[OCB-1:0];
            r_out_over    <= over;
            r_out_same    <= n_unch;
            r_out_last    <= r_in_last;
        end
    end

    // result packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_same, r_out_over, r_out_count,
                                   r_out_changed, r_out_set});

endmodule

`default_nettype wire

### src/fpk_checker.sv
`default_nettype none

module fpk_checker #(
    parameter int STATE_BITS = 11,
    parameter int OUT_W      = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int SB  = STATE_BITS;
    localparam int OCB = fpk_pkg::OUT_CNT_BITS;

    logic [SB-1:0] out_set;
    logic          out_changed;
    logic          out_over;
    logic          out_same;

    // result fields
    assign out_set     = m_axis_tdata[SB-1:0];
    assign out_changed = m_axis_tdata[SB];
    assign out_over    = m_axis_tdata[SB + 1 + OCB];
    assign out_same    = m_axis_tdata[SB + 2 + OCB];

    // a stalled result transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // over limit only comes from insertion cost, which reports an empty unchanged set
    a_over_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_over) |-> (out_set == '0 && !out_changed))
        else $error("over limit on a set-producing action");

    // a changed character clears the all-same flag of its run
    a_same_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_changed) |-> !out_same)
        else $error("all same while changed");

endmodule

bind fitch_parsimony_character_kernel fpk_checker #(
    .STATE_BITS (STATE_BITS),
    .OUT_W      (OUT_W)
) u_fpk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/fitch_result_checker.sv
`timescale 1ns / 100ps

module fitch_result_checker #(
    parameter int SET_W = 11,
    parameter int IN_W  = 72,
    parameter int OUT_W = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [SET_W-1:0]                i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // left_set, right_set, node_set, parent_set, old_set, cost_limit, zero pad
    input  logic [IN_W-1:0]                 i_s_tdata,
    // action
    input  logic [fpk_pkg::ACTION_BITS-1:0] i_s_tuser,
    input  logic                            i_s_tlast,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // new_set, changed, running_count, over_limit, all_same, zero pad
    input  logic [OUT_W-1:0]                i_m_tdata,
    input  logic                            i_m_tlast,
    output int                              o_errors,
    output int                              o_pending
);

    import fpk_pkg::*;

    typedef struct packed {
        logic [SET_W-1:0]        new_set;
        logic                    changed;
        logic [OUT_CNT_BITS-1:0] running_count;
        logic                    over_limit;
        logic                    all_same;
        logic                    last_out;
    } t_char_result;

    t_char_result            expected_chars[$];
    logic [SET_W-1:0]        applicable;
    logic [OUT_CNT_BITS-1:0] step_count;
    logic                    run_unchanged;
    int                      errors = 0;

    assign o_errors = errors;

    // print one line per mismatch and count it
    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        begin
            $display("tb: mismatch on %s: got %0d, expected %0d at %0t",
                     field, got, want, $time);
            errors++;
        end
    endtask

    // saturating step or cost count
    task automatic bump_count();
        begin
            if (step_count != '1)
                step_count = step_count + 1'b1;
        end
    endtask

    // compute the result of one accepted character and queue it
    task automatic predict_character(input logic [IN_W-1:0] data,
                                     input logic [ACTION_BITS-1:0] user,
                                     input logic last);
        t_action              act;
        logic [SET_W-1:0]     l, r, n, a, old, res;
        logic [LIMIT_BITS-1:0] limit;
        logic                 chg, over;
        t_char_result         want;
        begin
            l     = data[0 +: SET_W];
            r     = data[SET_W +: SET_W];
            n     = data[2*SET_W +: SET_W];
            a     = data[3*SET_W +: SET_W];
            old   = data[4*SET_W +: SET_W];
            limit = data[5*SET_W +: LIMIT_BITS];
            act   = t_action'(user);
            res   = '0;
            chg   = 1'b0;
            over  = 1'b0;
            case (act)
                ACT_DOWNPASS: begin
                    if ((l & r) != '0) begin
                        res = l & r;
                    end else begin
                        res = l | r;
                        // both children applicable: masked union costs one step
                        if ((l & applicable) != '0 && (r & applicable) != '0) begin
                            res = res & applicable;
                            bump_count();
                        end
                    end
                    chg = (res != old);
                end
                ACT_UPPASS: begin
                    if ((n & a) == a)
                        res = n & a;
                    else if ((l & r) != '0)
                        res = n | (a & (l | r));
                    else if ((a & applicable) != '0 && (n & applicable) != '0)
                        res = (n | a) & applicable;
                    else
                        res = n | a;
                    chg = (res != old);
                end
                ACT_TIP: begin
                    // a tip holding only inapplicable keeps its old set
                    if (n != SET_W'(1) && (n & a) != '0)
                        res = n & a;
                    else
                        res = old;
                    chg = (res != old);
                end
                default: begin
                    if ((n & (l | r)) == '0)
                        bump_count();
                    over = (step_count > limit);
                end
            endcase
            if (chg)
                run_unchanged = 1'b0;
            want.new_set       = res;
            want.changed       = chg;
            want.running_count = step_count;
            want.over_limit    = over;
            want.all_same      = run_unchanged;
            want.last_out      = last;
            expected_chars.push_back(want);
            // a closing character restarts the run
            if (last) begin
                step_count    = '0;
                run_unchanged = 1'b1;
            end
        end
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_result();
        t_char_result want;
        begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected result", i_m_tdata, 0);
            end else begin
                want = expected_chars.pop_front();
                if (i_m_tdata[0 +: SET_W] != want.new_set)
                    report_mismatch("new_set", i_m_tdata[0 +: SET_W], want.new_set);
                if (i_m_tdata[SET_W] != want.changed)
                    report_mismatch("changed", i_m_tdata[SET_W], want.changed);
                if (i_m_tdata[SET_W+1 +: OUT_CNT_BITS] != want.running_count)
                    report_mismatch("running_count", i_m_tdata[SET_W+1 +: OUT_CNT_BITS],
                                    want.running_count);
                if (i_m_tdata[SET_W+OUT_CNT_BITS+1] != want.over_limit)
                    report_mismatch("over_limit", i_m_tdata[SET_W+OUT_CNT_BITS+1],
                                    want.over_limit);
                if (i_m_tdata[SET_W+OUT_CNT_BITS+2] != want.all_same)
                    report_mismatch("all_same", i_m_tdata[SET_W+OUT_CNT_BITS+2],
                                    want.all_same);
                if (i_m_tlast != want.last_out)
                    report_mismatch("last_out", i_m_tlast, want.last_out);
            end
        end
    endtask

    // watch configuration, input and result transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            applicable    = MASK_RESET[SET_W-1:0];
            step_count    = '0;
            run_unchanged = 1'b1;
            expected_chars.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                applicable = i_cfg_data;
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_character(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        o_pending = expected_chars.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import fpk_pkg::*;

    localparam int SET_W       = 11;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 32;
    localparam int PHASE_CHARS = 195;
    localparam int HOLD_CYCLES = 200;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic [SET_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]        s_axis_tdata  = '0;
    logic [ACTION_BITS-1:0] s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_ready;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   m_axis_tlast;
    int                     fail_count;
    int                     pending;

    bit                     idle_en       = 1'b1;
    int                     hold_requests = 0;
    int                     holds_done    = 0;
    int                     hold_left     = 0;
    int                     stall_left    = 0;

    always #1 i_clk = ~i_clk;

    fitch_parsimony_character_kernel i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fitch_result_checker #(
        .SET_W (SET_W),
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .o_errors    (fail_count),
        .o_pending   (pending)
    );

    // result receiver: long hold on request, random stall bursts otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // offer one character and wait for its transaction
    task automatic send_character(input t_action act, input logic [SET_W-1:0] l,
                                  input logic [SET_W-1:0] r, input logic [SET_W-1:0] n,
                                  input logic [SET_W-1:0] a, input logic [SET_W-1:0] old,
                                  input logic [LIMIT_BITS-1:0] limit, input logic last);
        int gap;
        begin
            if (idle_en && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 11);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {1'b0, limit, old, a, n, r, l};
            s_axis_tuser  <= act;
            s_axis_tlast  <= last;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result has come out
    task automatic drain_results();
        begin
            s_axis_tvalid <= 1'b0;
            // let the count of outstanding results settle past the last transaction
            @(negedge i_clk);
            while (pending != 0) @(negedge i_clk);
            repeat (4) @(posedge i_clk);
        end
    endtask

    task automatic write_applicable_mask(input logic [SET_W-1:0] value);
        begin
            drain_results();
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // state sets biased toward empty, inapplicable-only, full and sparse sets
    function automatic logic [SET_W-1:0] rand_set();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SET_W'(1);
            2:       return '1;
            3:       return SET_W'(1) << $urandom_range(1, SET_W - 1);
            4:       return (SET_W'(1) << $urandom_range(0, SET_W - 1)) |
                            (SET_W'(1) << $urandom_range(0, SET_W - 1));
            default: return SET_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_BITS-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_BITS'($urandom);
            default: return LIMIT_BITS'($urandom_range(0, 12));
        endcase
    endfunction

    // one run of characters closed by tlast; quiet runs leave every set unchanged
    task automatic send_random_run(inout int sent);
        int               len;
        bit               quiet;
        t_action          act;
        logic [SET_W-1:0] l, r, n, a, old;
        begin
            len   = $urandom_range(1, 12);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                act = t_action'($urandom_range(0, 3));
                l   = rand_set();
                r   = rand_set();
                n   = rand_set();
                a   = rand_set();
                old = rand_set();
                if (quiet) begin
                    case (act)
                        ACT_DOWNPASS: begin
                            r   = l;
                            old = l;
                        end
                        ACT_UPPASS: begin
                            a   = n & a;
                            old = a;
                        end
                        ACT_TIP: n = SET_W'(1);
                        default: ;
                    endcase
                end else if (act == ACT_UPPASS && $urandom_range(0, 2) == 0) begin
                    // parent inside the node set
                    a = n & a;
                end
                send_character(act, l, r, n, a, old, rand_limit(), i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic run_random_phase();
        int sent;
        begin
            sent = 0;
            while (sent < PHASE_CHARS) send_random_run(sent);
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed characters with the reset mask
        send_character(ACT_DOWNPASS, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_DOWNPASS, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF, 1'b0);
        send_character(ACT_DOWNPASS, 11'h002, 11'h004, 11'h000, 11'h000, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_DOWNPASS, 11'h001, 11'h004, 11'h000, 11'h000, 11'h005, 16'h0000, 1'b0);
        send_character(ACT_DOWNPASS, 11'h7FE, 11'h001, 11'h000, 11'h000, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_UPPASS,   11'h000, 11'h000, 11'h006, 11'h002, 11'h002, 16'h0000, 1'b0);
        send_character(ACT_UPPASS,   11'h002, 11'h006, 11'h008, 11'h004, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_UPPASS,   11'h002, 11'h004, 11'h008, 11'h010, 11'h018, 16'h0000, 1'b0);
        send_character(ACT_UPPASS,   11'h002, 11'h004, 11'h001, 11'h010, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_UPPASS,   11'h7FF, 11'h000, 11'h000, 11'h7FF, 11'h7FF, 16'h0000, 1'b1);
        send_character(ACT_TIP,      11'h000, 11'h000, 11'h001, 11'h001, 11'h2AA, 16'h0000, 1'b0);
        send_character(ACT_TIP,      11'h000, 11'h000, 11'h00E, 11'h006, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_TIP,      11'h000, 11'h000, 11'h008, 11'h006, 11'h555, 16'h0000, 1'b0);
        send_character(ACT_TIP,      11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF, 1'b1);
        send_character(ACT_INSCOST,  11'h002, 11'h004, 11'h008, 11'h000, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_INSCOST,  11'h002, 11'h000, 11'h002, 11'h000, 11'h000, 16'h0000, 1'b0);
        send_character(ACT_INSCOST,  11'h000, 11'h000, 11'h000, 11'h7FF, 11'h7FF, 16'h0001, 1'b0);
        send_character(ACT_INSCOST,  11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 16'hFFFF, 1'b1);
        send_character(ACT_INSCOST,  11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'h0000, 1'b1);
        send_character(ACT_DOWNPASS, 11'h7FF, 11'h7FF, 11'h000, 11'h000, 11'h7FF, 16'h0000, 1'b1);

        // random runs across several mask settings
        run_random_phase();
        write_applicable_mask(11'h7FF);
        hold_requests++;
        run_random_phase();
        write_applicable_mask(11'h000);
        run_random_phase();
        write_applicable_mask(11'h001);
        run_random_phase();
        write_applicable_mask(SET_W'($urandom));
        hold_requests++;
        run_random_phase();
        write_applicable_mask(SET_W'($urandom));
        run_random_phase();

        // last part without idling
        write_applicable_mask(MASK_RESET[SET_W-1:0]);
        idle_en = 1'b0;
        run_random_phase();

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

### sim.f
src/fpk_pkg.sv
src/fpk_set_logic.sv
src/fitch_parsimony_character_kernel.sv
src/fpk_checker.sv
tb/fitch_result_checker.sv
tb/tb.sv
